// ----- src/kcri_pkg.sv -----
// ----------------------------------------------------------------------------
// kcri_pkg
// Shared types and codes for the keyframe Catmull-Rom interpolator.
// ----------------------------------------------------------------------------
package kcri_pkg;

  localparam int DIV_W   = 32;
  localparam int COEF_W  = 37;
  localparam int VIDX_W  = 12;
  localparam int COORD_W = 32;

  localparam logic [1:0] OP_SET_KEY   = 2'd0;
  localparam logic [1:0] OP_LOAD_VERT = 2'd1;
  localparam logic [1:0] OP_INTERP    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_KEY_COUNT    = 1'b0;
  localparam logic REG_FRAME_PERIOD = 1'b1;

  localparam logic [3:0] KEY_COUNT_RST    = 4'd5;
  localparam logic [7:0] FRAME_PERIOD_RST = 8'd20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_WRITE,
    S_SEARCH,
    S_MODR,
    S_MODO,
    S_DIVU,
    S_READ,
    S_COEF,
    S_MUL,
    S_ADD,
    S_FIN,
    S_DONE
  } kcri_state_e;

  typedef struct packed {
    logic [3:0] key_count;
    logic [7:0] frame_period;
  } kcri_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [1:0]         status;
  } kcri_res_t;

endpackage

// ----- src/keyframe_catmull_rom_interpolator.sv -----
// ----------------------------------------------------------------------------
// keyframe_catmull_rom_interpolator
// Keyframe table, vertex stores and Catmull-Rom evaluation with APB config.
// Key-frame load is written in idle, with no busy state. Vertex load subtracts
//   MAX_VERTS from vertex_index until in range (never for MAX_VERTS >= 4096).
// Interpolate: reduction, key search, three divisions on the shared divider,
//   memory fetch, Horner steps on one multiplier and a final clamp; one item
//   in flight. Reset clears control and config registers; stores start undefined.
// ----------------------------------------------------------------------------
module keyframe_catmull_rom_interpolator #(
  parameter int MAX_KEYS  = 8,
  parameter int MAX_VERTS = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [2:0]  key_index_i,
  input  logic [11:0] vertex_index_i,
  input  logic [7:0]  frame_number_i,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic [31:0] in_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [1:0]  status_o
);

  kcri_pkg::kcri_cfg_t cfg_q, cfg_d;
  kcri_pkg::kcri_res_t res, out_q, out_d;
  logic                res_valid, res_ready;
  logic                out_valid_q, out_valid_d;
  logic                cfg_wr;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == kcri_pkg::REG_FRAME_PERIOD) ? {24'd0, cfg_q.frame_period}
                                                              : {28'd0, cfg_q.key_count};
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[2])
        kcri_pkg::REG_KEY_COUNT:    cfg_d.key_count    = pwdata[3:0];
        kcri_pkg::REG_FRAME_PERIOD: cfg_d.frame_period = pwdata[7:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_count    <= kcri_pkg::KEY_COUNT_RST;
      cfg_q.frame_period <= kcri_pkg::FRAME_PERIOD_RST;
      out_valid_q        <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  kcri_core #(
    .MAX_KEYS  (MAX_KEYS),
    .MAX_VERTS (MAX_VERTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .key_index_i    (key_index_i),
    .vertex_index_i (vertex_index_i),
    .frame_number_i (frame_number_i),
    .in_x_i         (in_x_i),
    .in_y_i         (in_y_i),
    .in_z_i         (in_z_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_q.x;
  assign out_y_o     = out_q.y;
  assign out_z_o     = out_q.z;
  assign status_o    = out_q.status;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (operation_i == kcri_pkg::OP_LOAD_VERT || operation_i == kcri_pkg::OP_INTERP)
    |=> in_stall_o)
    else $error("core not busy after accepting work");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != kcri_pkg::ST_OK
    |-> out_x_o == 32'd0 && out_y_o == 32'd0 && out_z_o == 32'd0)
    else $error("error result carries nonzero coordinates");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> out_valid_o && out_q == $past(res))
    else $error("core result not captured in output register");

endmodule

// ----- src/kcri_div.sv -----
// ----------------------------------------------------------------------------
// kcri_div
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
// ----------------------------------------------------------------------------
module kcri_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kcri_pkg::DIV_W-1:0] dividend_i,
  input  logic [7:0]                divisor_i,
  output logic                      done_o,
  output logic [kcri_pkg::DIV_W-1:0] quot_o,
  output logic [7:0]                rem_o
);

  localparam int CW = $clog2(kcri_pkg::DIV_W);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [kcri_pkg::DIV_W-1:0] num_q, num_d;
  logic [7:0]                 den_q, den_d;
  logic [7:0]                 rem_q, rem_d;
  logic [8:0]                 trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[kcri_pkg::DIV_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 8'(trial - {1'b0, den_q});
        num_d = {num_q[kcri_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        num_d = {num_q[kcri_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(kcri_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/kcri_ram.sv -----
// ----------------------------------------------------------------------------
// kcri_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module kcri_ram #(
  parameter int AW = 15,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/kcri_core.sv -----
// ----------------------------------------------------------------------------
// kcri_core
// Sequencer: keyframe search, shared divider, vertex fetch, Horner cubic.
// ----------------------------------------------------------------------------
module kcri_core #(
  parameter int MAX_KEYS  = 8,
  parameter int MAX_VERTS = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kcri_pkg::kcri_cfg_t cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [2:0]          key_index_i,
  input  logic [11:0]         vertex_index_i,
  input  logic [7:0]          frame_number_i,
  input  logic [31:0]         in_x_i,
  input  logic [31:0]         in_y_i,
  input  logic [31:0]         in_z_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output kcri_pkg::kcri_res_t res_o
);

  localparam int KW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int VW = $clog2(MAX_VERTS);
  localparam int AW = KW + VW;
  localparam int UW = FRAC_BITS + 1;
  localparam int CW = kcri_pkg::COEF_W;
  localparam int PW = CW + UW + 1;
  localparam int DW = kcri_pkg::DIV_W;
  localparam logic signed [CW-1:0] SMAX = {{(CW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [CW-1:0] SMIN = {{(CW-31){1'b1}}, {31{1'b0}}};

  typedef struct packed {
    logic [1:0]             op;
    logic [2:0]             slot;
    logic [7:0]             f;
    logic [11:0]            vtx;
    logic [31:0]            x;
    logic [31:0]            y;
    logic [31:0]            z;
    logic [NW-1:0]          idx;
    logic [KW-1:0]          i1;
    logic [7:0]             t0;
    logic [7:0]             range;
    logic [UW-1:0]          u;
    logic [2:0]             rcnt;
    logic [1:0]             coord;
    logic [1:0]             step;
    logic [3:0][31:0]       px;
    logic [3:0][31:0]       py;
    logic [3:0][31:0]       pz;
    logic [3:0][CW-1:0]     c;
    logic [CW-1:0]          t;
    logic [PW-1:0]          prod;
    logic [2:0][31:0]       res;
    logic [1:0]             status;
  } dp_t;

  kcri_pkg::kcri_state_e state_q, state_d;
  dp_t                   dp_q, dp_d;
  logic [7:0]            kft_q [MAX_KEYS];
  logic                  kft_we;
  logic [KW-1:0]         kft_widx;
  logic [7:0]            kft_rd;
  logic [4:0]            slot_ext;
  logic                  slot_ok;
  logic [NW-1:0]         n_eff;
  logic [NW-1:0]         n_last;
  logic [7:0]            per;
  logic                  div_start;
  logic [DW-1:0]         div_dividend;
  logic [7:0]            div_divisor;
  logic                  div_done;
  logic [DW-1:0]         div_quot;
  logic [7:0]            div_rem;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [VW-1:0]         vaddr;
  logic [KW-1:0]         i0, im, i2, rkey;
  logic [31:0]           rd_x, rd_y, rd_z;
  logic [3:0][31:0]      p;
  logic signed [CW-1:0]  s0, s1, s2, s3, d12, hsum, sh;
  logic signed [PW-1:0]  prod_full;

  assign slot_ext = {2'b00, dp_q.slot};
  assign slot_ok  = int'(slot_ext) < MAX_KEYS;
  assign per      = (cfg_i.frame_period == 8'd0) ? 8'd1 : cfg_i.frame_period;
  assign vaddr    = VW'(dp_q.vtx);
  assign kft_rd   = kft_q[dp_q.idx[KW-1:0]];
  assign n_last   = n_eff - 1'b1;
  assign i0       = dp_q.i1 - 1'b1;
  assign im       = (i0 == '0) ? '0 : i0 - 1'b1;
  assign i2       = (dp_q.i1 == n_last[KW-1:0]) ? n_last[KW-1:0] : dp_q.i1 + 1'b1;
  assign mem_waddr = {KW'(dp_q.slot), vaddr};
  assign mem_raddr = {rkey, vaddr};

  always_comb begin
    if (cfg_i.key_count < 4'd2) begin
      n_eff = NW'(2);
    end else if (int'(cfg_i.key_count) > MAX_KEYS) begin
      n_eff = NW'(MAX_KEYS);
    end else begin
      n_eff = NW'(cfg_i.key_count);
    end
  end

  always_comb begin
    case (dp_q.rcnt)
      3'd0:    rkey = im;
      3'd1:    rkey = i0;
      3'd2:    rkey = dp_q.i1;
      default: rkey = i2;
    endcase
  end

  always_comb begin
    case (dp_q.coord)
      2'd0:    p = dp_q.px;
      2'd1:    p = dp_q.py;
      default: p = dp_q.pz;
    endcase
    s0   = {{(CW-32){p[0][31]}}, p[0]};
    s1   = {{(CW-32){p[1][31]}}, p[1]};
    s2   = {{(CW-32){p[2][31]}}, p[2]};
    s3   = {{(CW-32){p[3][31]}}, p[3]};
    d12  = s1 - s2;
    prod_full = PW'($signed(dp_q.t)) * PW'($signed({1'b0, dp_q.u}));
    sh   = CW'($signed(dp_q.prod) >>> FRAC_BITS);
    hsum = $signed(dp_q.t) >>> 1;
  end

  always_comb begin
    state_d      = state_q;
    dp_d         = dp_q;
    kft_we       = 1'b0;
    kft_widx     = KW'(key_index_i);
    mem_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = per;
    case (state_q)
      kcri_pkg::S_IDLE: begin
        if (in_valid_i) begin
          dp_d.op   = operation_i;
          dp_d.slot = key_index_i;
          dp_d.vtx  = vertex_index_i;
          dp_d.f    = frame_number_i;
          dp_d.x    = in_x_i;
          dp_d.y    = in_y_i;
          dp_d.z    = in_z_i;
          case (operation_i)
            kcri_pkg::OP_SET_KEY: begin
              kft_we = int'({2'b00, key_index_i}) < MAX_KEYS;
            end
            kcri_pkg::OP_LOAD_VERT,
            kcri_pkg::OP_INTERP: begin
              state_d = kcri_pkg::S_REDUCE;
            end
            default: state_d = kcri_pkg::S_IDLE;
          endcase
        end
      end
      kcri_pkg::S_REDUCE: begin
        if (int'(dp_q.vtx) >= MAX_VERTS) begin
          dp_d.vtx = dp_q.vtx - 12'(MAX_VERTS);
        end else if (dp_q.op == kcri_pkg::OP_LOAD_VERT) begin
          state_d = slot_ok ? kcri_pkg::S_WRITE : kcri_pkg::S_IDLE;
        end else begin
          dp_d.idx = '0;
          state_d  = kcri_pkg::S_SEARCH;
        end
      end
      kcri_pkg::S_WRITE: begin
        mem_we  = 1'b1;
        state_d = kcri_pkg::S_IDLE;
      end
      kcri_pkg::S_SEARCH: begin
        if (kft_rd > dp_q.f) begin
          if (dp_q.idx == '0) begin
            dp_d.status = kcri_pkg::ST_RANGE;
            dp_d.res    = '0;
            state_d     = kcri_pkg::S_DONE;
          end else begin
            dp_d.i1      = dp_q.idx[KW-1:0];
            div_start    = 1'b1;
            div_dividend = DW'({24'd0, kft_rd}) - DW'({24'd0, dp_q.t0});
            state_d      = kcri_pkg::S_MODR;
          end
        end else begin
          dp_d.t0 = kft_rd;
          if (dp_q.idx == n_last) begin
            dp_d.status = kcri_pkg::ST_RANGE;
            dp_d.res    = '0;
            state_d     = kcri_pkg::S_DONE;
          end else begin
            dp_d.idx = dp_q.idx + 1'b1;
          end
        end
      end
      kcri_pkg::S_MODR: begin
        if (div_done) begin
          dp_d.range = div_rem;
          if (div_rem == 8'd0) begin
            dp_d.status = kcri_pkg::ST_EMPTY;
            dp_d.res    = '0;
            state_d     = kcri_pkg::S_DONE;
          end else begin
            div_start    = 1'b1;
            div_dividend = DW'({24'd0, dp_q.f}) - DW'({24'd0, dp_q.t0});
            state_d      = kcri_pkg::S_MODO;
          end
        end
      end
      kcri_pkg::S_MODO: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_divisor  = dp_q.range;
          div_dividend = (div_rem > dp_q.range) ? (DW'(dp_q.range) << FRAC_BITS)
                                                : (DW'(div_rem) << FRAC_BITS);
          state_d      = kcri_pkg::S_DIVU;
        end
      end
      kcri_pkg::S_DIVU: begin
        if (div_done) begin
          dp_d.u    = div_quot[UW-1:0];
          dp_d.rcnt = '0;
          state_d   = kcri_pkg::S_READ;
        end
      end
      kcri_pkg::S_READ: begin
        if (dp_q.rcnt != 3'd0) begin
          dp_d.px[2'(dp_q.rcnt - 1'b1)] = rd_x;
          dp_d.py[2'(dp_q.rcnt - 1'b1)] = rd_y;
          dp_d.pz[2'(dp_q.rcnt - 1'b1)] = rd_z;
        end
        dp_d.rcnt = dp_q.rcnt + 1'b1;
        if (dp_q.rcnt == 3'd4) begin
          dp_d.coord = '0;
          state_d    = kcri_pkg::S_COEF;
        end
      end
      kcri_pkg::S_COEF: begin
        dp_d.c[0] = s1 <<< 1;
        dp_d.c[1] = s2 - s0;
        dp_d.c[2] = (s0 <<< 1) - (s1 <<< 2) - s1 + (s2 <<< 2) - s3;
        dp_d.c[3] = (d12 <<< 1) + d12 + s3 - s0;
        dp_d.t    = (d12 <<< 1) + d12 + s3 - s0;
        dp_d.step = '0;
        state_d   = kcri_pkg::S_MUL;
      end
      kcri_pkg::S_MUL: begin
        dp_d.prod = prod_full;
        state_d   = kcri_pkg::S_ADD;
      end
      kcri_pkg::S_ADD: begin
        dp_d.t = $signed(dp_q.c[2'(2'd2 - dp_q.step)]) + sh;
        if (dp_q.step == 2'd2) begin
          state_d = kcri_pkg::S_FIN;
        end else begin
          dp_d.step = dp_q.step + 1'b1;
          state_d   = kcri_pkg::S_MUL;
        end
      end
      kcri_pkg::S_FIN: begin
        if (hsum > SMAX) begin
          dp_d.res[dp_q.coord] = SMAX[31:0];
        end else if (hsum < SMIN) begin
          dp_d.res[dp_q.coord] = SMIN[31:0];
        end else begin
          dp_d.res[dp_q.coord] = hsum[31:0];
        end
        if (dp_q.coord == 2'd2) begin
          dp_d.status = kcri_pkg::ST_OK;
          state_d     = kcri_pkg::S_DONE;
        end else begin
          dp_d.coord = dp_q.coord + 1'b1;
          state_d    = kcri_pkg::S_COEF;
        end
      end
      kcri_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = kcri_pkg::S_IDLE;
        end
      end
      default: state_d = kcri_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kcri_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q <= dp_d;
    if (kft_we) begin
      kft_q[kft_widx] <= frame_number_i;
    end
  end

  kcri_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  kcri_ram #(.AW(AW), .DW(32)) u_ram_x (
    .clk_i (clk_i), .we_i (mem_we), .waddr_i (mem_waddr), .wdata_i (dp_q.x),
    .raddr_i (mem_raddr), .rdata_o (rd_x)
  );

  kcri_ram #(.AW(AW), .DW(32)) u_ram_y (
    .clk_i (clk_i), .we_i (mem_we), .waddr_i (mem_waddr), .wdata_i (dp_q.y),
    .raddr_i (mem_raddr), .rdata_o (rd_y)
  );

  kcri_ram #(.AW(AW), .DW(32)) u_ram_z (
    .clk_i (clk_i), .we_i (mem_we), .waddr_i (mem_waddr), .wdata_i (dp_q.z),
    .raddr_i (mem_raddr), .rdata_o (rd_z)
  );

  assign in_stall_o   = (state_q != kcri_pkg::S_IDLE);
  assign res_valid_o  = (state_q == kcri_pkg::S_DONE);
  assign res_o.x      = dp_q.res[0];
  assign res_o.y      = dp_q.res[1];
  assign res_o.z      = dp_q.res[2];
  assign res_o.status = dp_q.status;

endmodule
